// ----- src/ble_cet_pkg.sv -----
// ---------------------------------------------------------------------------
// BLE connection event tracker package
// Shared widths, reset values, outcome codes and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package ble_cet_pkg;

   localparam int CFG_TICK_W = 24;
   localparam int CFG_PS_W   = 25;
   localparam int CNT_W      = 32;
   localparam int OUTCOME_W  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [CFG_TICK_W-1:0] CONN_INTERVAL_RST     = 24'd32768;
   localparam logic [CFG_PS_W-1:0]   INTERVAL_REM_RST      = 25'd0;
   localparam logic [CFG_PS_W-1:0]   TICK_LENGTH_RST       = 25'd30517578;
   localparam logic [CFG_TICK_W-1:0] SUPERVISION_TICKS_RST = 24'd65536;
   localparam logic [CFG_TICK_W-1:0] CONNECT_END_RST       = 24'd0;
   localparam logic [CFG_TICK_W-1:0] ANCHOR_OFFSET_RST     = 24'd0;
   localparam logic [CFG_PS_W-1:0]   OFFSET_REM_RST        = 25'd0;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_GOOD = 2'd0,
      OUTCOME_MISS = 2'd1,
      OUTCOME_CRC  = 2'd2
   } outcome_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CONN_INTERVAL     = 3'd0,
      REG_INTERVAL_REM      = 3'd1,
      REG_TICK_LENGTH       = 3'd2,
      REG_SUPERVISION_TICKS = 3'd3,
      REG_CONNECT_END       = 3'd4,
      REG_ANCHOR_OFFSET     = 3'd5,
      REG_OFFSET_REM        = 3'd6
   } reg_index_type;

endpackage

`default_nettype wire

// ----- src/ble_cet_if.sv -----
// ---------------------------------------------------------------------------
// BLE connection event tracker channel interfaces
// Valid/ready channels for event items, result items and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface ble_cet_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   logic       peer_sn;
   logic       peer_nesn;

   modport source (output valid, output outcome, output peer_sn, output peer_nesn,
                   input ready);
   modport sink   (input valid, input outcome, input peer_sn, input peer_nesn,
                   output ready);
endinterface

interface ble_cet_rsp_if #(
   parameter int TICK_BITS = 24
);
   logic                 valid;
   logic                 ready;
   logic                 our_sn;
   logic                 our_nesn;
   logic [TICK_BITS-1:0] event_anchor;
   logic [TICK_BITS-1:0] following_anchor;
   logic [31:0]          miss_run;
   logic [31:0]          worst_miss_run;
   logic [31:0]          events_done;
   logic [31:0]          good_count;
   logic [31:0]          timeout_count;
   logic [31:0]          crc_fail_count;
   logic                 disconnect;

   modport source (output valid, output our_sn, output our_nesn, output event_anchor,
                   output following_anchor, output miss_run, output worst_miss_run,
                   output events_done, output good_count, output timeout_count,
                   output crc_fail_count, output disconnect, input ready);
   modport sink   (input valid, input our_sn, input our_nesn, input event_anchor,
                   input following_anchor, input miss_run, input worst_miss_run,
                   input events_done, input good_count, input timeout_count,
                   input crc_fail_count, input disconnect, output ready);
endinterface

interface ble_cet_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [24:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ble_conn_event_tracker_top.sv -----
// ---------------------------------------------------------------------------
// BLE connection event tracker
// Slave connection event bookkeeping: SN/NESN, counters, supervision
// timeout and anchor advance with picosecond carry.
//
//   channel   | dir | carries
//   ----------+-----+---------------------------------------------
//   req_chan  | in  | outcome, peer_sn, peer_nesn
//   rsp_chan  | out | sequence bits, anchors, counters, disconnect
//   csr_chan  | in  | register index and write data
//
// One item per cycle sustained while rsp is ready; a req passes through the
// input register, then the result register, before rsp valid.
// The per-item path is one 32-bit increment/compare and the anchor add
// with a single fraction carry.
// A stalled rsp holds its result; the input register keeps taking one more item.
// Synchronous reset loads register defaults and the initial anchor.
// ---------------------------------------------------------------------------
`default_nettype none

module ble_conn_event_tracker_top #(
   parameter int TICK_BITS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   ble_cet_req_if.sink       req_chan,
   ble_cet_rsp_if.source     rsp_chan,
   ble_cet_csr_if.sink       csr_chan
);
   import ble_cet_pkg::*;

   localparam int CMP_W = (TICK_BITS > CFG_TICK_W) ? TICK_BITS : CFG_TICK_W;

   // configuration
   logic [CFG_TICK_W-1:0] conn_interval_ff, conn_interval_in;
   logic [CFG_PS_W-1:0]   interval_rem_ff, interval_rem_in;
   logic [CFG_PS_W-1:0]   tick_length_ff, tick_length_in;
   logic [CFG_TICK_W-1:0] supervision_ff, supervision_in;
   logic [CFG_TICK_W-1:0] connect_end_ff, connect_end_in;
   logic [CFG_TICK_W-1:0] anchor_offset_ff, anchor_offset_in;
   logic [CFG_PS_W-1:0]   offset_rem_ff, offset_rem_in;

   // connection state
   logic                 sn_ff, sn_in;
   logic                 nesn_ff, nesn_in;
   logic [TICK_BITS-1:0] anchor_ff, anchor_in;
   logic [CFG_PS_W-1:0]  fraction_ff, fraction_in;
   logic [TICK_BITS-1:0] last_good_ff, last_good_in;
   logic [CNT_W-1:0]     misses_ff, misses_in;
   logic [CNT_W-1:0]     worst_ff, worst_in;
   logic [CNT_W-1:0]     events_ff, events_in;
   logic [CNT_W-1:0]     good_ff, good_in;
   logic [CNT_W-1:0]     timeout_ff, timeout_in;
   logic [CNT_W-1:0]     crc_ff, crc_in;
   logic                 ended_ff, ended_in;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [OUTCOME_W-1:0] s1_outcome_ff;
   logic                 s1_sn_ff;
   logic                 s1_nesn_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TICK_BITS-1:0] rsp_ev_anchor_ff;

   logic advance;
   logic req_take;
   logic csr_take;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign csr_take = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      logic [CNT_W-1:0]     miss_inc;
      logic [TICK_BITS-1:0] gap;
      logic                 end_now;
      logic [CFG_PS_W:0]    frac_sum;
      logic                 carry;
      logic [TICK_BITS-1:0] step_ticks;

      conn_interval_in  = conn_interval_ff;
      interval_rem_in   = interval_rem_ff;
      tick_length_in    = tick_length_ff;
      supervision_in    = supervision_ff;
      connect_end_in    = connect_end_ff;
      anchor_offset_in  = anchor_offset_ff;
      offset_rem_in     = offset_rem_ff;

      sn_in        = sn_ff;
      nesn_in      = nesn_ff;
      anchor_in    = anchor_ff;
      fraction_in  = fraction_ff;
      last_good_in = last_good_ff;
      misses_in    = misses_ff;
      worst_in     = worst_ff;
      events_in    = events_ff;
      good_in      = good_ff;
      timeout_in   = timeout_ff;
      crc_in       = crc_ff;
      ended_in     = ended_ff;

      miss_inc   = misses_ff + 1'b1;
      gap        = anchor_ff - last_good_ff;
      end_now    = CMP_W'(gap) >= CMP_W'(supervision_ff);
      frac_sum   = {1'b0, fraction_ff} + {1'b0, interval_rem_ff};
      carry      = frac_sum >= {1'b0, tick_length_ff};
      step_ticks = TICK_BITS'(conn_interval_ff) + TICK_BITS'(carry);

      if (advance && !ended_ff) begin
         events_in = events_ff + 1'b1;
         case (outcome_type'(s1_outcome_ff))
            OUTCOME_GOOD: begin
               good_in      = good_ff + 1'b1;
               sn_in        = s1_nesn_ff;
               nesn_in      = nesn_ff ^ (s1_sn_ff == nesn_ff);
               last_good_in = anchor_ff;
               misses_in    = '0;
               end_now      = 1'b0;
            end
            OUTCOME_CRC: begin
               crc_in = crc_ff + 1'b1;
            end
            default: begin
               timeout_in = timeout_ff + 1'b1;
            end
         endcase
         if (outcome_type'(s1_outcome_ff) != OUTCOME_GOOD) begin
            misses_in = miss_inc;
            if (miss_inc > worst_ff) begin
               worst_in = miss_inc;
            end
         end
         ended_in = end_now;
         if (!end_now) begin
            anchor_in   = anchor_ff + step_ticks;
            fraction_in = carry ? CFG_PS_W'(frac_sum - {1'b0, tick_length_ff})
                                : frac_sum[CFG_PS_W-1:0];
         end
      end

      if (csr_take) begin
         case (reg_index_type'(csr_chan.index))
            REG_CONN_INTERVAL:     conn_interval_in  = csr_chan.data[CFG_TICK_W-1:0];
            REG_INTERVAL_REM:      interval_rem_in   = csr_chan.data;
            REG_TICK_LENGTH:       tick_length_in    = csr_chan.data;
            REG_SUPERVISION_TICKS: supervision_in    = csr_chan.data[CFG_TICK_W-1:0];
            REG_CONNECT_END: begin
               connect_end_in = csr_chan.data[CFG_TICK_W-1:0];
               last_good_in   = TICK_BITS'(connect_end_in);
            end
            REG_ANCHOR_OFFSET:     anchor_offset_in  = csr_chan.data[CFG_TICK_W-1:0];
            REG_OFFSET_REM:        offset_rem_in     = csr_chan.data;
            default: ;
         endcase
         if (csr_chan.index == REG_CONNECT_END || csr_chan.index == REG_ANCHOR_OFFSET ||
             csr_chan.index == REG_OFFSET_REM) begin
            anchor_in   = TICK_BITS'(connect_end_in) + TICK_BITS'(anchor_offset_in);
            fraction_in = offset_rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_interval_ff  <= CONN_INTERVAL_RST;
         interval_rem_ff   <= INTERVAL_REM_RST;
         tick_length_ff    <= TICK_LENGTH_RST;
         supervision_ff    <= SUPERVISION_TICKS_RST;
         connect_end_ff    <= CONNECT_END_RST;
         anchor_offset_ff  <= ANCHOR_OFFSET_RST;
         offset_rem_ff     <= OFFSET_REM_RST;
         sn_ff             <= 1'b0;
         nesn_ff           <= 1'b0;
         anchor_ff         <= TICK_BITS'(CONNECT_END_RST) + TICK_BITS'(ANCHOR_OFFSET_RST);
         fraction_ff       <= OFFSET_REM_RST;
         last_good_ff      <= TICK_BITS'(CONNECT_END_RST);
         misses_ff         <= '0;
         worst_ff          <= '0;
         events_ff         <= '0;
         good_ff           <= '0;
         timeout_ff        <= '0;
         crc_ff            <= '0;
         ended_ff          <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         conn_interval_ff  <= conn_interval_in;
         interval_rem_ff   <= interval_rem_in;
         tick_length_ff    <= tick_length_in;
         supervision_ff    <= supervision_in;
         connect_end_ff    <= connect_end_in;
         anchor_offset_ff  <= anchor_offset_in;
         offset_rem_ff     <= offset_rem_in;
         sn_ff             <= sn_in;
         nesn_ff           <= nesn_in;
         anchor_ff         <= anchor_in;
         fraction_ff       <= fraction_in;
         last_good_ff      <= last_good_in;
         misses_ff         <= misses_in;
         worst_ff          <= worst_in;
         events_ff         <= events_in;
         good_ff           <= good_in;
         timeout_ff        <= timeout_in;
         crc_ff            <= crc_in;
         ended_ff          <= ended_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_outcome_ff <= req_chan.outcome;
         s1_sn_ff      <= req_chan.peer_sn;
         s1_nesn_ff    <= req_chan.peer_nesn;
      end
      if (advance) begin
         rsp_ev_anchor_ff <= anchor_ff;
      end
   end

   // result fields mirror the state written on the same edge as the result
   // register; state moves again on the next advance, which also requires a
   // pending result to be taken, or on a register write
   logic [CNT_W-1:0]     rsp_misses_ff, rsp_worst_ff, rsp_events_ff;
   logic [CNT_W-1:0]     rsp_good_ff, rsp_timeout_ff, rsp_crc_ff;
   logic [TICK_BITS-1:0] rsp_following_anchor_ff;
   logic                 rsp_sn_ff, rsp_nesn_ff, rsp_ended_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sn_ff               <= sn_in;
         rsp_nesn_ff             <= nesn_in;
         rsp_following_anchor_ff <= anchor_in;
         rsp_misses_ff           <= misses_in;
         rsp_worst_ff            <= worst_in;
         rsp_events_ff           <= events_in;
         rsp_good_ff             <= good_in;
         rsp_timeout_ff          <= timeout_in;
         rsp_crc_ff              <= crc_in;
         rsp_ended_ff            <= ended_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.our_sn           = rsp_sn_ff;
   assign rsp_chan.our_nesn         = rsp_nesn_ff;
   assign rsp_chan.event_anchor     = rsp_ev_anchor_ff;
   assign rsp_chan.following_anchor = rsp_following_anchor_ff;
   assign rsp_chan.miss_run         = rsp_misses_ff;
   assign rsp_chan.worst_miss_run   = rsp_worst_ff;
   assign rsp_chan.events_done      = rsp_events_ff;
   assign rsp_chan.good_count       = rsp_good_ff;
   assign rsp_chan.timeout_count    = rsp_timeout_ff;
   assign rsp_chan.crc_fail_count   = rsp_crc_ff;
   assign rsp_chan.disconnect       = rsp_ended_ff;

endmodule

`default_nettype wire
